// ----- src/rtcs_pkg.sv -----
// Package for the RTC two-wire time sync sequencer: phase, command and
// transfer codes, reset values, BCD helper functions and the decode bundle.
// No dependencies.
`timescale 1ns / 1ps

package rtcs_pkg;

  // Phase codes of the transfer sequencer
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_PTR   = 3'd2;
  localparam logic [2:0] PH_READ  = 3'd3;
  localparam logic [2:0] PH_WRITE = 3'd4;

  // Latched command codes
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_GET  = 2'd1;
  localparam logic [1:0] CMD_SET  = 2'd2;

  // Input word kinds
  localparam logic [1:0] REQ_POLL = 2'd0;
  localparam logic [1:0] REQ_GET  = 2'd1;
  localparam logic [1:0] REQ_SET  = 2'd2;

  // Bus transfer kinds
  localparam logic [1:0] XK_PTR   = 2'd0;
  localparam logic [1:0] XK_READ  = 2'd1;
  localparam logic [1:0] XK_WRITE = 2'd2;

  // Configuration register indexes and reset values
  localparam logic       REG_RETRY_LIMIT = 1'b0;
  localparam logic       REG_WAIT_LIMIT  = 1'b1;
  localparam logic [3:0]  RETRY_LIMIT_RST = 4'd3;
  localparam logic [15:0] WAIT_LIMIT_RST  = 16'd15000;

  // Stream widths
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 112;

  // Fields produced by decoding one clock register read
  typedef struct packed {
    logic [5:0]  sec;
    logic [35:0] time_bin;
    logic [11:0] temp_tenths;
  } rtcs_decode_t;

  // Two BCD digits to binary (high*10 + low), malformed digits included.
  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    bcd_dec = {4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]};
  endfunction

  // Binary to two BCD digits; tens come from a reciprocal multiply by 205/2048,
  // exact for every 7-bit value.
  function automatic logic [7:0] bcd_enc(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = {8'd0, v} * 15'd205;
    tens = prod[14:11];
    ones = v - {3'd0, tens} * 7'd10;
    bcd_enc = {tens, ones[3:0]};
  endfunction

endpackage

// ----- src/rtc_i2c_time_sync_sequencer.sv -----
// Top level of the RTC two-wire time sync sequencer: stream ports, APB-style
// configuration, state step and result register. Depends on rtcs_pkg and
// rtcs_time_decode.
`timescale 1ns / 1ps

// Usage
// The input stream carries one word per request or poll. in_tuser holds the
// word kind: a request latches a get-time or set-time command, a poll steps
// the transfer phases using the bus status and received registers in tdata.
// Every accepted word produces exactly one result word on the output stream,
// carrying the new phase, transfer launch, BCD write data, bus reset flag,
// decoded time and stored temperature; out_tuser holds the transfer kind.
// A word lands in the input register on acceptance; the state step reads it
// there and writes the output register, which presents the result.
// Throughput is one word per cycle while the receiver takes each result; the
// state step is a single short pass of BCD logic between the input register
// and the output register. When the receiver stalls, the output register
// holds its word and the input register holds the next one; in_tready drops
// only while both are full. Reset (rst_n low, synchronous) empties both
// registers, returns the phase to idle, clears the command and counters and
// loads the register defaults (retry limit 3, wait limit 15000). The user is
// to write configuration while idle; the block itself does not enforce it.

module rtc_i2c_time_sync_sequencer import rtcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata fields from bit 0: bus_busy, bus_ok, rx_time[56], rx_temp[16],
  // set_seconds[6], set_minutes[6], set_hours[5], set_day[5], set_month[4],
  // set_year[7], set_dow[3], zero pad[2]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser fields from bit 0: req_type[2]
  input  logic [1:0]            in_tuser,
  // out_tdata fields from bit 0: phase_code[3], req_done, start_xfer,
  // tx_time[56], bus_reset, time_valid, out_time[36], temperature[12], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser fields from bit 0: xfer_kind[2]
  output logic [1:0]            out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // Configuration registers
  logic [3:0]  retry_limit_r;
  logic [15:0] wait_limit_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_LIMIT_RST;
      wait_limit_r  <= WAIT_LIMIT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_RETRY_LIMIT) begin
        retry_limit_r <= cfg_pwdata[3:0];
      end else begin
        wait_limit_r <= cfg_pwdata[15:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_RETRY_LIMIT) ? {28'd0, retry_limit_r}
                                                        : {16'd0, wait_limit_r};

  // Input register and handshake
  logic                 in_valid_r;
  logic [IN_DATA_W-1:0] in_data_r;
  logic [1:0]           in_user_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]           out_user_r;
  logic                 advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_user_r <= in_tuser;
    end
  end

  // Unpacked fields of the held word
  logic        f_busy, f_ok;
  logic [55:0] f_rx_time;
  logic [15:0] f_rx_temp;
  logic [5:0]  f_sec, f_min;
  logic [4:0]  f_hours, f_day;
  logic [3:0]  f_month;
  logic [6:0]  f_year;
  logic [2:0]  f_dow;

  assign f_busy    = in_data_r[0];
  assign f_ok      = in_data_r[1];
  assign f_rx_time = in_data_r[57:2];
  assign f_rx_temp = in_data_r[73:58];
  assign f_sec     = in_data_r[79:74];
  assign f_min     = in_data_r[85:80];
  assign f_hours   = in_data_r[90:86];
  assign f_day     = in_data_r[95:91];
  assign f_month   = in_data_r[99:96];
  assign f_year    = in_data_r[106:100];
  assign f_dow     = in_data_r[109:107];

  rtcs_decode_t dec;

  rtcs_time_decode u_decode (
    .rx_time (f_rx_time),
    .rx_temp (f_rx_temp),
    .dec     (dec)
  );

  // Sequencer state
  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  command_r, command_nxt;
  logic        finished_r, finished_nxt;
  logic [3:0]  retry_r, retry_nxt;
  logic [16:0] wait_r, wait_nxt;
  logic [5:0]  prev_sec_r, prev_sec_nxt;
  logic        prev_valid_r, prev_valid_nxt;
  logic [11:0] temp_r, temp_nxt;

  // Result fields
  logic        req_done, start_xfer, bus_reset, time_valid;
  logic [1:0]  xfer_kind;
  logic [55:0] tx_time;
  logic [35:0] time_out;

  logic        active, cmd_known, fail, finish;
  logic [4:0]  retry_inc;
  logic        give_up;
  logic [16:0] wait_inc;
  logic        wait_over;
  logic [1:0]  want;
  logic [55:0] tx_enc;

  assign cmd_known = (command_r == CMD_GET) || (command_r == CMD_SET);
  assign active    = cmd_known && !finished_r;
  assign retry_inc = {1'b0, retry_r} + 5'd1;
  assign give_up   = retry_inc > {1'b0, retry_limit_r};
  assign wait_inc  = wait_r + 17'd1;
  assign wait_over = wait_inc > {1'b0, wait_limit_r};
  assign want      = (in_user_r == REQ_GET) ? CMD_GET : CMD_SET;

  // BCD write data: seconds, minutes, hours, dow, day, month, year from the low byte
  assign tx_enc = {bcd_enc(f_year), bcd_enc({3'd0, f_month}), bcd_enc({2'd0, f_day}),
                   {5'd0, f_dow}, bcd_enc({2'd0, f_hours}), bcd_enc({1'b0, f_min}),
                   bcd_enc({1'b0, f_sec})};

  // One state step per held word
  always_comb begin
    phase_nxt      = phase_r;
    command_nxt    = command_r;
    finished_nxt   = finished_r;
    retry_nxt      = retry_r;
    wait_nxt       = wait_r;
    prev_sec_nxt   = prev_sec_r;
    prev_valid_nxt = prev_valid_r;
    temp_nxt       = temp_r;
    req_done       = 1'b0;
    start_xfer     = 1'b0;
    xfer_kind      = XK_PTR;
    tx_time        = '0;
    bus_reset      = 1'b0;
    time_valid     = 1'b0;
    time_out       = '0;
    fail           = 1'b0;
    finish         = 1'b0;

    unique case (in_user_r)
      REQ_POLL: begin
        unique case (phase_r)
          PH_START: begin
            wait_nxt = '0;
            if (active && command_r == CMD_GET) begin
              start_xfer = 1'b1;
              xfer_kind  = XK_PTR;
              phase_nxt  = PH_PTR;
            end else if (active) begin
              start_xfer = 1'b1;
              xfer_kind  = XK_WRITE;
              tx_time    = tx_enc;
              phase_nxt  = PH_WRITE;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_PTR: begin
            if (f_busy) begin
              wait_nxt = wait_inc;
              fail     = wait_over;
            end else if (f_ok) begin
              start_xfer = 1'b1;
              xfer_kind  = XK_READ;
              phase_nxt  = PH_READ;
              retry_nxt  = '0;
            end else begin
              fail = 1'b1;
            end
          end
          PH_READ: begin
            if (f_busy) begin
              wait_nxt = wait_inc;
              fail     = wait_over;
            end else if (f_ok) begin
              // Reread until the seconds move on from the previous read
              if (!prev_valid_r) begin
                prev_sec_nxt   = dec.sec;
                prev_valid_nxt = 1'b1;
                phase_nxt      = PH_START;
              end else if (prev_sec_r == dec.sec) begin
                phase_nxt = PH_START;
              end else begin
                time_valid     = 1'b1;
                time_out       = dec.time_bin;
                prev_valid_nxt = 1'b0;
                temp_nxt       = dec.temp_tenths;
                finish         = 1'b1;
              end
            end else begin
              fail = 1'b1;
            end
          end
          PH_WRITE: begin
            if (f_busy) begin
              wait_nxt = wait_inc;
              fail     = wait_over;
            end else if (f_ok) begin
              finish = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          default: begin
            wait_nxt  = '0;
            phase_nxt = active ? PH_START : PH_IDLE;
          end
        endcase
      end
      REQ_GET, REQ_SET: begin
        if (!cmd_known) begin
          command_nxt  = want;
          finished_nxt = 1'b0;
        end else if (finished_r) begin
          if (command_r == want) begin
            command_nxt = CMD_NONE;
            req_done    = 1'b1;
          end else begin
            command_nxt = want;
          end
          finished_nxt = 1'b0;
        end
      end
      default: begin
        // Unknown word kind leaves the state alone
      end
    endcase

    // A failed attempt resets the bus and retries or gives up
    if (fail) begin
      bus_reset = 1'b1;
      if (give_up) begin
        finish = 1'b1;
      end else begin
        retry_nxt = retry_inc[3:0];
        phase_nxt = PH_START;
      end
    end
    if (finish) begin
      finished_nxt = 1'b1;
      phase_nxt    = PH_IDLE;
      retry_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      command_r    <= CMD_NONE;
      finished_r   <= 1'b0;
      retry_r      <= '0;
      wait_r       <= '0;
      prev_sec_r   <= '0;
      prev_valid_r <= 1'b0;
      temp_r       <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      command_r    <= command_nxt;
      finished_r   <= finished_nxt;
      retry_r      <= retry_nxt;
      wait_r       <= wait_nxt;
      prev_sec_r   <= prev_sec_nxt;
      prev_valid_r <= prev_valid_nxt;
      temp_r       <= temp_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {1'b0, temp_nxt, time_out, time_valid, bus_reset, tx_time,
                     start_xfer, req_done, phase_nxt};
      out_user_r <= xfer_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Checks on the sequencer

  // The input side only stalls behind a full, stalled output register.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without an output stall");

  // A reported completion always clears the command.
  a_done_clears_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && req_done) |=> (command_r == CMD_NONE && !finished_r))
    else $error("completion reported but command still latched");

  // Delivered time always ends the command in the idle phase.
  a_time_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[62]) |-> (out_data_r[2:0] == PH_IDLE))
    else $error("time delivered outside idle");

  // No transfer launched means no transfer kind and no write data.
  a_quiet_when_no_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r[4]) |-> (out_user_r == XK_PTR && out_data_r[60:5] == '0))
    else $error("transfer fields set without a launch");

  // A bus reset lands either on a retry start or on giving up.
  a_reset_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[61]) |->
      (out_data_r[2:0] == PH_START || out_data_r[2:0] == PH_IDLE))
    else $error("bus reset with unexpected phase");

endmodule

// ----- src/rtcs_time_decode.sv -----
// Decoder for one clock register read: BCD time to packed binary fields and
// the temperature to tenths of a degree. Depends on rtcs_pkg.
`timescale 1ns / 1ps

module rtcs_time_decode import rtcs_pkg::*; (
  input  logic [55:0]  rx_time,
  input  logic [15:0]  rx_temp,
  output rtcs_decode_t dec
);

  logic [7:0] b_sec, b_min, b_hour, b_dow, b_day, b_month, b_year;
  logic [7:0] sec_full, min_full, day_full, year_full;
  logic [4:0] hr12_base, hr12_adj, month_bin;
  logic [5:0] hr12_pm, hr24;
  logic [4:0] hour_bin;
  logic [11:0] temp_int;
  logic [11:0] temp_tenths;

  assign {b_year, b_month, b_day, b_dow, b_hour, b_min, b_sec} = rx_time;

  assign sec_full  = bcd_dec(b_sec);
  assign min_full  = bcd_dec(b_min);
  assign day_full  = bcd_dec(b_day);
  assign year_full = bcd_dec(b_year);

  // Hours: in 12-hour mode twelve counts as zero and PM adds twelve.
  assign hr12_base = (b_hour[4] ? 5'd10 : 5'd0) + {1'b0, b_hour[3:0]};
  assign hr12_adj  = (hr12_base == 5'd12) ? 5'd0 : hr12_base;
  assign hr12_pm   = b_hour[5] ? ({1'b0, hr12_adj} + 6'd12) : {1'b0, hr12_adj};
  assign hr24      = {4'd0, b_hour[5:4]} * 6'd10 + {2'd0, b_hour[3:0]};
  assign hour_bin  = b_hour[6] ? hr12_pm[4:0] : hr24[4:0];

  // Month ignores the century flag.
  assign month_bin = (b_month[4] ? 5'd10 : 5'd0) + {1'b0, b_month[3:0]};

  assign dec.sec = sec_full[5:0];
  assign dec.time_bin = {b_dow[2:0], year_full[6:0], month_bin[3:0], day_full[4:0],
                         hour_bin, min_full[5:0], sec_full[5:0]};

  // Temperature: integer byte times ten plus the rounded quarter-degree fraction.
  assign temp_int = {4'd0, rx_temp[15:8]} * 12'd10;

  always_comb begin
    unique case (rx_temp[7:6])
      2'd1:    temp_tenths = temp_int + 12'd3;
      2'd2:    temp_tenths = temp_int + 12'd5;
      2'd3:    temp_tenths = temp_int + 12'd8;
      default: temp_tenths = temp_int;
    endcase
  end

  assign dec.temp_tenths = temp_tenths;

endmodule
